// ===== rtl/mlsp_pkg.sv =====
// Package for the MPLS label stack parser: phase and code enums, result
// record, label rule constants. No dependencies.
`timescale 1ns / 1ps

package mlsp_pkg;

    localparam int MAX_LABELS_DEFAULT = 16;
    localparam int FIFO_DEPTH         = 4;

    // Reserved labels and GACH channel types
    localparam logic [19:0] LBL_IPV4_NULL   = 20'd0;
    localparam logic [19:0] LBL_ROUTER_ALRT = 20'd1;
    localparam logic [19:0] LBL_IPV6_NULL   = 20'd2;
    localparam logic [19:0] LBL_IMPL_NULL   = 20'd3;
    localparam logic [19:0] LBL_GAL         = 20'd13;
    localparam logic [15:0] CT_IPV4         = 16'h0021;
    localparam logic [15:0] CT_IPV6         = 16'h0057;
    localparam logic [3:0]  NIB_IPV4        = 4'h4;
    localparam logic [3:0]  NIB_IPV6        = 4'h6;
    localparam logic [3:0]  ACH_FIRST_NIB   = 4'h1;
    localparam logic [6:0]  OFFSET_MAX      = 7'd127;

    typedef enum logic [1:0] {
        PH_LABEL   = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DRAIN   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_NO_BOTTOM = 3'd2,
        ERR_EMPTY_PL  = 3'd3,
        ERR_SHORT_ACH = 3'd4,
        ERR_TOO_DEEP  = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        PL_RAW  = 2'd0,
        PL_IPV4 = 2'd1,
        PL_IPV6 = 2'd2
    } pl_kind_t;

    typedef enum logic {
        RK_ENTRY   = 1'b0,
        RK_SUMMARY = 1'b1
    } rkind_t;

    typedef struct packed {
        rkind_t      result_kind;
        logic [19:0] label;
        logic [2:0]  tclass;
        logic        bottom;
        logic [7:0]  ttl;
        logic        malformed;
        err_t        end_error;
        pl_kind_t    payload_kind;
        logic        gach_present;
        logic [15:0] chan_type;
        logic [6:0]  payload_offset;
        logic        last_result;
    } result_t;

    // Results produced by one parsed byte, in output order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/mlsp_parse.sv =====
// Parse stage of the MPLS label stack parser: per-packet state registers and
// the combinational next-state and result logic. Depends on mlsp_pkg.
`timescale 1ns / 1ps

module mlsp_parse #(
    parameter int MAX_LABELS = mlsp_pkg::MAX_LABELS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              packet_end,
    output mlsp_pkg::push_t   push
);

    localparam int CW = $clog2(MAX_LABELS + 1);

    logic [1:0]          bie_reg, bie_next;
    logic [23:0]         ebytes_reg, ebytes_next;
    mlsp_pkg::phase_t    phase_reg, phase_next;
    logic [19:0]         last_reg, last_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                bad_reg, bad_next;
    mlsp_pkg::err_t      err_reg, err_next;
    logic [6:0]          off_reg, off_next;
    logic [2:0]          seen_reg, seen_next;
    logic [31:0]         gach_reg, gach_next;

    logic [31:0]         word;
    logic [19:0]         e_label;
    logic                e_bot;
    logic                e_bad;
    logic                entry_done;
    logic [31:0]         off_wide;
    mlsp_pkg::result_t   entry_res;
    mlsp_pkg::result_t   sum_res;
    logic [7:0]          ach_first;
    logic [7:0]          ach_rsvd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bie_reg    <= '0;
            ebytes_reg <= '0;
            phase_reg  <= mlsp_pkg::PH_LABEL;
            last_reg   <= '0;
            count_reg  <= '0;
            bad_reg    <= 1'b0;
            err_reg    <= mlsp_pkg::ERR_NONE;
            off_reg    <= '0;
            seen_reg   <= '0;
            gach_reg   <= '0;
        end
        else if (fire)
        begin
            bie_reg    <= packet_end ? '0 : bie_next;
            ebytes_reg <= packet_end ? '0 : ebytes_next;
            phase_reg  <= packet_end ? mlsp_pkg::PH_LABEL : phase_next;
            last_reg   <= packet_end ? '0 : last_next;
            count_reg  <= packet_end ? '0 : count_next;
            bad_reg    <= packet_end ? 1'b0 : bad_next;
            err_reg    <= packet_end ? mlsp_pkg::ERR_NONE : err_next;
            off_reg    <= packet_end ? '0 : off_next;
            seen_reg   <= packet_end ? '0 : seen_next;
            gach_reg   <= packet_end ? '0 : gach_next;
        end
    end

    assign word    = {ebytes_reg, data_byte};
    assign e_label = word[31:12];
    assign e_bot   = word[8];
    assign e_bad   = (e_label == mlsp_pkg::LBL_IMPL_NULL)
                   || ((e_label == mlsp_pkg::LBL_IPV4_NULL
                        || e_label == mlsp_pkg::LBL_IPV6_NULL) && !e_bot)
                   || (e_label == mlsp_pkg::LBL_ROUTER_ALRT && e_bot)
                   || (e_label == mlsp_pkg::LBL_GAL && !e_bot);

    // Per-byte state advance
    always_comb
    begin
        bie_next    = bie_reg;
        ebytes_next = ebytes_reg;
        phase_next  = phase_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        err_next    = err_reg;
        off_next    = off_reg;
        seen_next   = seen_reg;
        gach_next   = gach_reg;
        entry_done  = 1'b0;
        off_wide    = 32'(count_reg + CW'(1)) << 2;
        unique case (phase_reg)
            mlsp_pkg::PH_LABEL:
            begin
                if (bie_reg == 2'd0 && count_reg >= CW'(MAX_LABELS))
                begin
                    phase_next = mlsp_pkg::PH_DRAIN;
                    err_next   = mlsp_pkg::ERR_TOO_DEEP;
                    bad_next   = 1'b1;
                end
                else if (bie_reg != 2'd3)
                begin
                    ebytes_next = {ebytes_reg[15:0], data_byte};
                    bie_next    = bie_reg + 2'd1;
                end
                else
                begin
                    entry_done  = 1'b1;
                    bad_next    = bad_reg | e_bad;
                    last_next   = e_label;
                    count_next  = count_reg + CW'(1);
                    bie_next    = '0;
                    ebytes_next = '0;
                    if (e_bot)
                    begin
                        off_next   = (off_wide > 32'(mlsp_pkg::OFFSET_MAX))
                                   ? mlsp_pkg::OFFSET_MAX : off_wide[6:0];
                        phase_next = mlsp_pkg::PH_PAYLOAD;
                    end
                end
            end
            mlsp_pkg::PH_PAYLOAD:
            begin
                if (seen_reg < 3'd4)
                begin
                    seen_next = seen_reg + 3'd1;
                    unique case (seen_reg[1:0])
                        2'd0:    gach_next[31:24] = data_byte;
                        2'd1:    gach_next[23:16] = data_byte;
                        2'd2:    gach_next[15:8]  = data_byte;
                        default: gach_next[7:0]   = data_byte;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Entry result for a completed four-byte entry
    always_comb
    begin
        entry_res               = '0;
        entry_res.result_kind   = mlsp_pkg::RK_ENTRY;
        entry_res.label         = e_label;
        entry_res.tclass        = word[11:9];
        entry_res.bottom        = e_bot;
        entry_res.ttl           = word[7:0];
        entry_res.malformed     = e_bad;
        entry_res.end_error     = mlsp_pkg::ERR_NONE;
        entry_res.payload_kind  = mlsp_pkg::PL_RAW;
        entry_res.last_result   = !packet_end;
    end

    assign ach_first = gach_next[31:24];
    assign ach_rsvd  = gach_next[23:16];

    // Packet summary, taken from the state after this byte
    always_comb
    begin
        sum_res                = '0;
        sum_res.result_kind    = mlsp_pkg::RK_SUMMARY;
        sum_res.label          = last_next;
        sum_res.malformed      = bad_next;
        sum_res.end_error      = err_next;
        sum_res.payload_kind   = mlsp_pkg::PL_RAW;
        sum_res.payload_offset = off_next;
        sum_res.last_result    = 1'b1;
        unique case (phase_next)
            mlsp_pkg::PH_LABEL:
            begin
                sum_res.end_error = (bie_next != 2'd0) ? mlsp_pkg::ERR_TRUNCATED
                                                       : mlsp_pkg::ERR_NO_BOTTOM;
                sum_res.malformed = 1'b1;
            end
            mlsp_pkg::PH_PAYLOAD:
            begin
                priority if (seen_next == 3'd0)
                begin
                    sum_res.end_error = mlsp_pkg::ERR_EMPTY_PL;
                    sum_res.malformed = 1'b1;
                end
                else if (last_next == mlsp_pkg::LBL_GAL)
                begin
                    if (seen_next < 3'd4)
                    begin
                        sum_res.end_error = mlsp_pkg::ERR_SHORT_ACH;
                        sum_res.malformed = 1'b1;
                    end
                    else
                    begin
                        sum_res.gach_present = 1'b1;
                        sum_res.chan_type    = gach_next[15:0];
                        if (ach_first[7:4] != mlsp_pkg::ACH_FIRST_NIB
                            || ach_first[3:0] != 4'd0 || ach_rsvd != 8'd0)
                        begin
                            sum_res.malformed = 1'b1;
                        end
                        if (gach_next[15:0] == mlsp_pkg::CT_IPV4)
                        begin
                            sum_res.payload_kind = mlsp_pkg::PL_IPV4;
                        end
                        else if (gach_next[15:0] == mlsp_pkg::CT_IPV6)
                        begin
                            sum_res.payload_kind = mlsp_pkg::PL_IPV6;
                        end
                    end
                end
                else if (last_next == mlsp_pkg::LBL_IPV4_NULL)
                begin
                    sum_res.payload_kind = mlsp_pkg::PL_IPV4;
                    if (gach_next[31:28] != mlsp_pkg::NIB_IPV4)
                    begin
                        sum_res.malformed = 1'b1;
                    end
                end
                else if (last_next == mlsp_pkg::LBL_IPV6_NULL)
                begin
                    sum_res.payload_kind = mlsp_pkg::PL_IPV6;
                    if (gach_next[31:28] != mlsp_pkg::NIB_IPV6)
                    begin
                        sum_res.malformed = 1'b1;
                    end
                end
                else if (gach_next[31:28] == mlsp_pkg::NIB_IPV4)
                begin
                    sum_res.payload_kind = mlsp_pkg::PL_IPV4;
                end
                else if (gach_next[31:28] == mlsp_pkg::NIB_IPV6)
                begin
                    sum_res.payload_kind = mlsp_pkg::PL_IPV6;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push.count  = 2'd0;
        push.first  = entry_res;
        push.second = sum_res;
        if (fire)
        begin
            if (entry_done)
            begin
                push.count = packet_end ? 2'd2 : 2'd1;
            end
            else if (packet_end)
            begin
                push.count = 2'd1;
                push.first = sum_res;
            end
        end
    end

endmodule

// ===== rtl/mlsp_result_fifo.sv =====
// Small result queue for the MPLS label stack parser: takes up to two results
// per cycle, hands out one per beat. Depends on mlsp_pkg.
`timescale 1ns / 1ps

module mlsp_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  mlsp_pkg::push_t   push,
    output logic              room,
    output logic              valid,
    input  logic              pop,
    output mlsp_pkg::result_t head
);

    localparam int DEPTH = mlsp_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    mlsp_pkg::result_t mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && valid;
    assign valid  = count_reg != '0;
    assign room   = count_reg <= (AW + 1)'(DEPTH - 2);
    assign head   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(do_pop);
        count_next  = count_reg + (AW + 1)'(push.count) - (AW + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/mpls_label_stack_parser.sv =====
// Top level of the MPLS label stack parser: input beat register, parse stage
// and result queue. Depends on mlsp_pkg, mlsp_parse, mlsp_result_fifo.
`timescale 1ns / 1ps

// Takes an MPLS packet one byte per beat (tlast on the final byte) and emits
// one result per completed four-byte label stack entry plus one summary at
// packet end; tuser says which (0 entry, 1 summary) and tlast marks the last
// result caused by an input byte. Each byte is held in an input register,
// parsed by one level of logic against the per-packet state and its results
// are written into a four-entry queue, so bytes stream at one per cycle while
// the output side keeps up. A byte that both completes an entry and ends the
// packet yields two results, each on its own output beat; the input stalls
// only while the queue lacks room for two results. A byte's results pass the
// input register and the queue before reaching the output. Entries beyond
// MAX_LABELS without a bottom bit are dropped and reported as stack too deep.
module mpls_label_stack_parser #(
    parameter int MAX_LABELS = mlsp_pkg::MAX_LABELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // packet_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // label, tclass, bottom, ttl, malformed,
                                    // end_error, payload_kind, gach_present,
                                    // chan_type, payload_offset, zero pad
    output logic        m_tuser,    // result_kind
    output logic        m_tlast     // last_result
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              room;
    logic              fire;
    mlsp_pkg::push_t   push;
    mlsp_pkg::result_t head;

    // Parse the held beat once the queue can take two results
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    mlsp_parse #(
        .MAX_LABELS (MAX_LABELS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (in_byte_reg),
        .packet_end (in_end_reg),
        .push       (push)
    );

    mlsp_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (m_tvalid),
        .pop   (m_tready),
        .head  (head)
    );

    // Pack the head result onto the output beat
    assign m_tuser = head.result_kind;
    assign m_tlast = head.last_result;
    assign m_tdata = {2'b00,
                      head.payload_offset,
                      head.chan_type,
                      head.gach_present,
                      head.payload_kind,
                      head.end_error,
                      head.malformed,
                      head.ttl,
                      head.bottom,
                      head.tclass,
                      head.label};

endmodule

// ===== test/mpls_label_stack_parser_test.sv =====
// Self-checking testbench for mpls_label_stack_parser: directed packets, then
// random MPLS packets checked beat by beat against a built-in parser model.
// Depends on mlsp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module mpls_label_stack_parser_test;

    localparam int DEPTH        = mlsp_pkg::MAX_LABELS_DEFAULT;
    localparam int ITEM_TARGET  = 1600;
    localparam int CALM_AT      = ITEM_TARGET - 200;
    localparam int HOLD_PKT     = 30;
    localparam int PAUSE_PKT    = 60;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 20;

    // One directed beat; pinned rows carry a summary code read straight off
    // the parsing rules instead of the model's answer.
    typedef struct packed {
        logic [7:0]     data;
        logic           eop;
        logic           pinned;
        mlsp_pkg::err_t err;
        logic           bad;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    mlsp_pkg::result_t expected_results[$];
    logic [7:0]  pkt_bytes[$];
    int          fail_count = 0;
    int unsigned bytes_in = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;
    bit          gap_free = 1'b0;
    bit          hold_off_req = 1'b0;

    // Shadow parser state
    mlsp_pkg::phase_t pp_phase;
    logic [1:0]  pp_nbytes;
    logic [23:0] pp_partial;
    logic [19:0] pp_last_label;
    int unsigned pp_entries;
    logic        pp_bad;
    mlsp_pkg::err_t pp_err;
    logic [6:0]  pp_offset;
    int unsigned pp_payload_cnt;
    logic [31:0] pp_payload;

    // Directed packets: a lone truncated byte, an all-zero entry with no
    // bottom, an all-ones bottom entry with nothing after it, a GAL entry
    // with a short GACH, and an IPv6 explicit null with a good payload.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h5a, 1'b1, 1'b1, mlsp_pkg::ERR_TRUNCATED, 1'b1},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b1, 1'b1, mlsp_pkg::ERR_NO_BOTTOM, 1'b1},
        '{8'hff, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'hff, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'hff, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'hff, 1'b1, 1'b1, mlsp_pkg::ERR_EMPTY_PL,  1'b1},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'hd1, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h40, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h10, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b1, 1'b1, mlsp_pkg::ERR_SHORT_ACH, 1'b1},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h00, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h21, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h3f, 1'b0, 1'b0, mlsp_pkg::ERR_NONE,      1'b0},
        '{8'h60, 1'b1, 1'b0, mlsp_pkg::ERR_NONE,      1'b0}
    };

    mpls_label_stack_parser #(
        .MAX_LABELS (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** mpls_label_stack_parser: FAILED **");
        $finish;
    end

    //------------------------------------------------------------------
    // Shadow parser
    //------------------------------------------------------------------
    function automatic logic label_breaks_rule(input logic [19:0] lbl, input logic bos);
        return (lbl == mlsp_pkg::LBL_IMPL_NULL) ||
               ((lbl == mlsp_pkg::LBL_IPV4_NULL || lbl == mlsp_pkg::LBL_IPV6_NULL) && !bos) ||
               (lbl == mlsp_pkg::LBL_ROUTER_ALRT && bos) ||
               (lbl == mlsp_pkg::LBL_GAL && !bos);
    endfunction

    task automatic parser_clear();
        pp_phase       = mlsp_pkg::PH_LABEL;
        pp_nbytes      = '0;
        pp_partial     = '0;
        pp_last_label  = '0;
        pp_entries     = 0;
        pp_bad         = 1'b0;
        pp_err         = mlsp_pkg::ERR_NONE;
        pp_offset      = '0;
        pp_payload_cnt = 0;
        pp_payload     = '0;
    endtask

    // Advance the shadow parser by one byte and queue the results it owes.
    task automatic parse_byte(input logic [7:0] b, input logic eop,
                              input logic pinned, input mlsp_pkg::err_t pin_err,
                              input logic pin_bad);
        mlsp_pkg::result_t ent;
        mlsp_pkg::result_t sum;
        logic [31:0] word;
        logic [3:0]  nib;
        bit          have_entry;

        ent = '0;
        have_entry = 1'b0;
        case (pp_phase)
            mlsp_pkg::PH_LABEL:
            begin
                if (pp_nbytes == 0 && pp_entries >= DEPTH)
                begin
                    // Stack too deep: drop everything up to packet end
                    pp_phase = mlsp_pkg::PH_DRAIN;
                    pp_err   = mlsp_pkg::ERR_TOO_DEEP;
                    pp_bad   = 1'b1;
                end
                else if (pp_nbytes < 3)
                begin
                    pp_partial = {pp_partial[15:0], b};
                    pp_nbytes  = pp_nbytes + 2'd1;
                end
                else
                begin
                    word              = {pp_partial, b};
                    ent.result_kind   = mlsp_pkg::RK_ENTRY;
                    ent.label         = word[31:12];
                    ent.tclass        = word[11:9];
                    ent.bottom        = word[8];
                    ent.ttl           = word[7:0];
                    ent.malformed     = label_breaks_rule(word[31:12], word[8]);
                    ent.end_error     = mlsp_pkg::ERR_NONE;
                    ent.payload_kind  = mlsp_pkg::PL_RAW;
                    have_entry        = 1'b1;
                    if (ent.malformed)
                        pp_bad = 1'b1;
                    pp_last_label = ent.label;
                    pp_entries++;
                    pp_nbytes  = '0;
                    pp_partial = '0;
                    if (ent.bottom)
                    begin
                        pp_offset = (pp_entries * 4 > 127) ? mlsp_pkg::OFFSET_MAX
                                                           : 7'(pp_entries * 4);
                        pp_phase  = mlsp_pkg::PH_PAYLOAD;
                    end
                end
            end
            mlsp_pkg::PH_PAYLOAD:
            begin
                if (pp_payload_cnt < 4)
                begin
                    pp_payload[31 - 8 * pp_payload_cnt -: 8] = b;
                    pp_payload_cnt++;
                end
            end
            default:
            begin
            end
        endcase

        if (have_entry)
        begin
            ent.last_result = !eop;
            expected_results.push_back(ent);
        end

        if (eop)
        begin
            sum                = '0;
            sum.result_kind    = mlsp_pkg::RK_SUMMARY;
            sum.label          = pp_last_label;
            sum.malformed      = pp_bad;
            sum.end_error      = pp_err;
            sum.payload_kind   = mlsp_pkg::PL_RAW;
            sum.payload_offset = pp_offset;
            sum.last_result    = 1'b1;
            if (pp_phase == mlsp_pkg::PH_LABEL)
            begin
                sum.end_error = (pp_nbytes != 0) ? mlsp_pkg::ERR_TRUNCATED
                                                 : mlsp_pkg::ERR_NO_BOTTOM;
                sum.malformed = 1'b1;
            end
            else if (pp_phase == mlsp_pkg::PH_PAYLOAD)
            begin
                if (pp_payload_cnt == 0)
                begin
                    sum.end_error = mlsp_pkg::ERR_EMPTY_PL;
                    sum.malformed = 1'b1;
                end
                else if (pp_last_label == mlsp_pkg::LBL_GAL)
                begin
                    if (pp_payload_cnt < 4)
                    begin
                        sum.end_error = mlsp_pkg::ERR_SHORT_ACH;
                        sum.malformed = 1'b1;
                    end
                    else
                    begin
                        sum.gach_present = 1'b1;
                        sum.chan_type    = pp_payload[15:0];
                        if (pp_payload[31:28] != mlsp_pkg::ACH_FIRST_NIB ||
                            pp_payload[27:24] != 4'h0 || pp_payload[23:16] != 8'h00)
                            sum.malformed = 1'b1;
                        if (pp_payload[15:0] == mlsp_pkg::CT_IPV4)
                            sum.payload_kind = mlsp_pkg::PL_IPV4;
                        else if (pp_payload[15:0] == mlsp_pkg::CT_IPV6)
                            sum.payload_kind = mlsp_pkg::PL_IPV6;
                    end
                end
                else
                begin
                    nib = pp_payload[31:28];
                    if (pp_last_label == mlsp_pkg::LBL_IPV4_NULL)
                    begin
                        sum.payload_kind = mlsp_pkg::PL_IPV4;
                        if (nib != mlsp_pkg::NIB_IPV4)
                            sum.malformed = 1'b1;
                    end
                    else if (pp_last_label == mlsp_pkg::LBL_IPV6_NULL)
                    begin
                        sum.payload_kind = mlsp_pkg::PL_IPV6;
                        if (nib != mlsp_pkg::NIB_IPV6)
                            sum.malformed = 1'b1;
                    end
                    else if (nib == mlsp_pkg::NIB_IPV4)
                        sum.payload_kind = mlsp_pkg::PL_IPV4;
                    else if (nib == mlsp_pkg::NIB_IPV6)
                        sum.payload_kind = mlsp_pkg::PL_IPV6;
                end
            end
            if (pinned)
            begin
                sum.end_error = pin_err;
                sum.malformed = pin_bad;
            end
            expected_results.push_back(sum);
            parser_clear();
        end
    endtask

    // Every accepted byte goes through the shadow parser.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (bytes_in < N_DIRECTED && directed_rows[bytes_in].pinned)
                parse_byte(s_tdata, s_tlast, 1'b1, directed_rows[bytes_in].err,
                           directed_rows[bytes_in].bad);
            else
                parse_byte(s_tdata, s_tlast, 1'b0, mlsp_pkg::ERR_NONE, 1'b0);
            bytes_in++;
        end
    end

    //------------------------------------------------------------------
    // Result checking
    //------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // m_tdata: [19:0] label, [22:20] tclass, [23] bottom, [31:24] ttl,
    // [32] malformed, [35:33] end_error, [37:36] payload_kind, [38] gach_present,
    // [54:39] chan_type, [61:55] payload_offset
    always @(posedge clk)
    begin
        mlsp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: tdata 0x%0h tuser %0b",
                       m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind",    want.result_kind,    m_tuser);
                check_field("label",          want.label,          m_tdata[19:0]);
                check_field("tclass",         want.tclass,         m_tdata[22:20]);
                check_field("bottom",         want.bottom,         m_tdata[23]);
                check_field("ttl",            want.ttl,            m_tdata[31:24]);
                check_field("malformed",      want.malformed,      m_tdata[32]);
                check_field("end_error",      want.end_error,      m_tdata[35:33]);
                check_field("payload_kind",   want.payload_kind,   m_tdata[37:36]);
                check_field("gach_present",   want.gach_present,   m_tdata[38]);
                check_field("chan_type",      want.chan_type,      m_tdata[54:39]);
                check_field("payload_offset", want.payload_offset, m_tdata[61:55]);
                check_field("last_result",    want.last_result,    m_tlast);
            end
        end
    end

    //------------------------------------------------------------------
    // Packet generation
    //------------------------------------------------------------------
    function automatic logic [19:0] pick_label();
        case ($urandom_range(0, 15))
            0:       return mlsp_pkg::LBL_IPV4_NULL;
            1:       return mlsp_pkg::LBL_ROUTER_ALRT;
            2:       return mlsp_pkg::LBL_IPV6_NULL;
            3:       return mlsp_pkg::LBL_IMPL_NULL;
            4:       return mlsp_pkg::LBL_GAL;
            5:       return 20'hfffff;
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] entry_word(input logic [19:0] lbl, input logic bos);
        return {lbl, 3'($urandom), bos, 8'($urandom)};
    endfunction

    task automatic push_word(input logic [31:0] word);
        pkt_bytes.push_back(word[31:24]);
        pkt_bytes.push_back(word[23:16]);
        pkt_bytes.push_back(word[15:8]);
        pkt_bytes.push_back(word[7:0]);
    endtask

    // Mostly well-formed stacks with random content; the rest are stacks near the
    // depth limit with no bottom entry, stacks cut mid-entry and raw noise.
    task automatic build_packet(input bit force_deep);
        int unsigned mode;
        int unsigned depth;
        int unsigned plen;
        int unsigned k;
        logic [19:0] lbl;
        logic [7:0]  lead;
        logic [31:0] ach;

        pkt_bytes.delete();
        mode = force_deep ? 13 : $urandom_range(0, 19);
        if (mode <= 12)
        begin
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(5, DEPTH) : $urandom_range(1, 4);
            for (k = 1; k < depth; k++)
                push_word(entry_word(pick_label(), $urandom_range(0, 15) == 0));
            lbl = ($urandom_range(0, 2) == 0) ? mlsp_pkg::LBL_GAL : pick_label();
            push_word(entry_word(lbl, 1'b1));
            if (lbl == mlsp_pkg::LBL_GAL)
            begin
                plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
                ach[31:24] = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h10;
                ach[23:16] = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00;
                case ($urandom_range(0, 2))
                    0:       ach[15:0] = mlsp_pkg::CT_IPV4;
                    1:       ach[15:0] = mlsp_pkg::CT_IPV6;
                    default: ach[15:0] = 16'($urandom);
                endcase
                for (k = 0; k < plen; k++)
                    pkt_bytes.push_back((k < 4) ? ach[31 - 8 * k -: 8] : 8'($urandom));
            end
            else
            begin
                plen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
                case ($urandom_range(0, 2))
                    0:       lead = {mlsp_pkg::NIB_IPV4, 4'($urandom)};
                    1:       lead = {mlsp_pkg::NIB_IPV6, 4'($urandom)};
                    default: lead = 8'($urandom);
                endcase
                for (k = 0; k < plen; k++)
                    pkt_bytes.push_back((k == 0) ? lead : 8'($urandom));
            end
        end
        else if (mode <= 14)
        begin
            // Around the depth limit: one short, exactly full, one over
            depth = force_deep ? DEPTH + 1 : $urandom_range(DEPTH - 1, DEPTH + 1);
            for (k = 0; k < depth; k++)
                push_word(entry_word(pick_label(), 1'b0));
            plen = $urandom_range(0, 6);
            for (k = 0; k < plen; k++)
                pkt_bytes.push_back(8'($urandom));
        end
        else if (mode <= 16)
        begin
            depth = $urandom_range(0, 3);
            for (k = 0; k < depth; k++)
                push_word(entry_word(pick_label(), 1'b0));
            plen = $urandom_range(1, 3);
            for (k = 0; k < plen; k++)
                pkt_bytes.push_back(8'($urandom));
        end
        else
        begin
            plen = $urandom_range(1, 12);
            for (k = 0; k < plen; k++)
                pkt_bytes.push_back(8'($urandom));
        end
    endtask

    //------------------------------------------------------------------
    // Sender: one beat per call, with optional gap in front
    //------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic eop);
        if (!calm && !gap_free && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none late
    initial
    begin
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                // Hold long enough for the result queue to fill and back up
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        int unsigned sent;
        int unsigned pkt_idx;
        int unsigned k;

        parser_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
            send_beat(directed_rows[k].data, directed_rows[k].eop);

        sent = 0;
        pkt_idx = 0;
        while (sent < ITEM_TARGET)
        begin
            // Open the random part with a stack one entry too deep
            build_packet(pkt_idx == 0);
            gap_free = ($urandom_range(0, 3) == 0);
            if (pkt_idx == HOLD_PKT)
                hold_off_req = 1'b1;
            if (pkt_idx == PAUSE_PKT)
            begin
                // Sender goes quiet until every owed result is out
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            calm = (sent >= CALM_AT);
            for (k = 0; k < pkt_bytes.size(); k++)
                send_beat(pkt_bytes[k], k == pkt_bytes.size() - 1);
            sent += pkt_bytes.size();
            pkt_idx++;
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** mpls_label_stack_parser: PASSED **");
        else
            $display("** mpls_label_stack_parser: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mlsp_pkg.sv
rtl/mlsp_parse.sv
rtl/mlsp_result_fifo.sv
rtl/mpls_label_stack_parser.sv
test/mpls_label_stack_parser_test.sv
